>>> rtl/core/fbrs_pkg.sv
// shared constants and types for the framebuffer region scroll block
package fbrs_pkg;

    localparam int MAX_W   = 256;
    localparam int MAX_H   = 256;
    localparam int DEPTH   = MAX_W * MAX_H;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW      = (MAX_W > 1) ? $clog2(MAX_W) : 1;
    localparam int YW      = (MAX_H > 1) ? $clog2(MAX_H) : 1;
    localparam int CW      = 14;
    localparam int PIX_W   = 32;
    localparam int SIZE_W  = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_SCROLL = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic          start;
        logic          desc_x;
        logic          desc_y;
        logic [AW-1:0] src;
        logic [AW-1:0] dst;
        logic [XW-1:0] cols_m1;
        logic [YW-1:0] rows_m1;
    } walk_cmd_t;

    typedef struct packed {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic          done;
    } walk_stat_t;

endpackage

>>> rtl/core/fbrs_ram.sv
// generic simple dual-port ram with registered read
module fbrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fbrs_walker.sv
// address sequencer that walks a copy rectangle one pixel per cycle
module fbrs_walker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbrs_pkg::walk_cmd_t    cmd,
    output fbrs_pkg::walk_stat_t   stat
);

    import fbrs_pkg::*;

    logic          active_reg, active_next;
    logic          desc_x_reg, desc_x_next;
    logic          desc_y_reg, desc_y_next;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [XW-1:0] cols_m1_reg, cols_m1_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [AW-1:0] row_src_reg, row_src_next;
    logic [AW-1:0] row_dst_reg, row_dst_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;

    logic [AW-1:0] nrow_src;
    logic [AW-1:0] nrow_dst;

    always_comb
    begin
        nrow_src = desc_y_reg ? (row_src_reg - AW'(MAX_W)) : (row_src_reg + AW'(MAX_W));
        nrow_dst = desc_y_reg ? (row_dst_reg - AW'(MAX_W)) : (row_dst_reg + AW'(MAX_W));
    end

    always_comb
    begin
        active_next  = active_reg;
        desc_x_next  = desc_x_reg;
        desc_y_next  = desc_y_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        cols_m1_next = cols_m1_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        row_src_next = row_src_reg;
        row_dst_next = row_dst_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        if (active_reg)
        begin
            wr_pend_next = 1'b1;
            wr_addr_next = dst_reg;
            if (col_reg != '0)
            begin
                col_next = col_reg - XW'(1);
                src_next = desc_x_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                dst_next = desc_x_reg ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));
            end
            else if (row_reg != '0)
            begin
                row_next     = row_reg - YW'(1);
                col_next     = cols_m1_reg;
                row_src_next = nrow_src;
                row_dst_next = nrow_dst;
                src_next     = nrow_src;
                dst_next     = nrow_dst;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else if (cmd.start)
        begin
            active_next  = 1'b1;
            desc_x_next  = cmd.desc_x;
            desc_y_next  = cmd.desc_y;
            col_next     = cmd.cols_m1;
            row_next     = cmd.rows_m1;
            cols_m1_next = cmd.cols_m1;
            src_next     = cmd.src;
            dst_next     = cmd.dst;
            row_src_next = cmd.src;
            row_dst_next = cmd.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_x_reg  <= desc_x_next;
        desc_y_reg  <= desc_y_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        cols_m1_reg <= cols_m1_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        row_src_reg <= row_src_next;
        row_dst_reg <= row_dst_next;
        wr_addr_reg <= wr_addr_next;
    end

    always_comb
    begin
        stat.rd_en   = active_reg;
        stat.rd_addr = src_reg;
        stat.wr_en   = wr_pend_reg;
        stat.wr_addr = wr_addr_reg;
        stat.done    = wr_pend_reg & ~active_reg;
    end

endmodule

>>> rtl/core/framebuffer_region_scroll.sv
// top level: pixel store, request sequencer, scroll setup and config registers
// pixel write, out-of-range access and unused request: result in the cycle after the transfer
// pixel read: registered ram read in S_READ, then the result is registered
// scroll: states S_CLIP, S_CHECK, S_ORIG, S_START, S_WALK; one pixel moved per cycle over the ram read/write ports
// a scroll that moves nothing ends in S_CHECK; req_ready low until the result transfer
// after reset a clearing pass writes zero to all 65536 words, req_ready low meanwhile
module framebuffer_region_scroll (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbrs_pkg::PADDR_W-1:0]     paddr,
    input  logic [fbrs_pkg::PDATA_W-1:0]     pwdata,
    output logic [fbrs_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [1:0]                       req_type,
    input  logic signed [10:0]               left,
    input  logic signed [10:0]               top,
    input  logic [9:0]                       span_w,
    input  logic [9:0]                       span_h,
    input  logic signed [10:0]               shift_x,
    input  logic signed [10:0]               shift_y,
    input  logic [fbrs_pkg::PIX_W-1:0]       pixel_in,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [fbrs_pkg::PIX_W-1:0]       pixel_out,
    output logic                             out_of_range
);

    import fbrs_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CLIP  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_ORIG  = 8'b0010_0000,
        S_START = 8'b0100_0000,
        S_WALK  = 8'b1000_0000
    } state_t;

    localparam logic signed [CW-1:0] MAX_W_S = CW'(MAX_W);
    localparam logic signed [CW-1:0] MAX_H_S = CW'(MAX_H);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] aw_reg, aw_next;
    logic [SIZE_W-1:0] ah_reg, ah_next;
    logic [AW-1:0]     clr_reg, clr_next;

    logic                  out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]      out_pix_reg, out_pix_next;
    logic                  out_oor_reg, out_oor_next;

    logic signed [CW-1:0]  l_reg, l_next;
    logic signed [CW-1:0]  t_reg, t_next;
    logic signed [CW-1:0]  w_reg, w_next;
    logic signed [CW-1:0]  h_reg, h_next;
    logic signed [CW-1:0]  dx_reg, dx_next;
    logic signed [CW-1:0]  dy_reg, dy_next;
    logic signed [CW-1:0]  x0_reg, x0_next;
    logic signed [CW-1:0]  y0_reg, y0_next;
    logic signed [CW-1:0]  cw_reg, cw_next;
    logic signed [CW-1:0]  ch_reg, ch_next;
    logic [XW-1:0]         ow_m1_reg, ow_m1_next;
    logic [YW-1:0]         oh_m1_reg, oh_m1_next;
    logic [XW-1:0]         sxf_reg, sxf_next;
    logic [YW-1:0]         syf_reg, syf_next;

    logic signed [CW-1:0]  l_in, t_in;
    logic signed [CW-1:0]  eff_w, eff_h;
    logic signed [CW-1:0]  l_end, t_end;
    logic signed [CW-1:0]  x1, y1;
    logic signed [CW-1:0]  adx, ady;
    logic signed [CW-1:0]  ow, oh;
    logic signed [CW-1:0]  sxf, syf;
    logic signed [CW-1:0]  dxf, dyf;
    logic                  skip;
    logic                  in_range;
    logic                  accept;
    logic                  cfg_wr;
    logic [AW-1:0]         pix_addr;

    walk_cmd_t  wcmd;
    walk_stat_t wstat;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    fbrs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbrs_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (wcmd),
        .stat  (wstat)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_HEIGHT) ? PDATA_W'(ah_reg) : PDATA_W'(aw_reg);

    always_comb
    begin
        aw_next = aw_reg;
        ah_next = ah_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                aw_next = pwdata[SIZE_W-1:0];
            end
            else
            begin
                ah_next = pwdata[SIZE_W-1:0];
            end
        end
    end

    // geometry
    always_comb
    begin
        eff_w = (CW'(aw_reg) > MAX_W_S) ? MAX_W_S : CW'(aw_reg);
        eff_h = (CW'(ah_reg) > MAX_H_S) ? MAX_H_S : CW'(ah_reg);
        l_in  = CW'(left);
        t_in  = CW'(top);
        in_range = (l_in >= 0) && (l_in < eff_w) && (t_in >= 0) && (t_in < eff_h);
        pix_addr = AW'(t_in[YW-1:0]) * AW'(MAX_W) + AW'(l_in[XW-1:0]);

        l_end = l_reg + w_reg;
        t_end = t_reg + h_reg;
        x1    = (l_end < eff_w) ? l_end : eff_w;
        y1    = (t_end < eff_h) ? t_end : eff_h;

        adx  = (dx_reg < 0) ? -dx_reg : dx_reg;
        ady  = (dy_reg < 0) ? -dy_reg : dy_reg;
        skip = (cw_reg <= 0) || (ch_reg <= 0) || ((dx_reg == 0) && (dy_reg == 0))
               || (adx >= cw_reg) || (ady >= ch_reg);
        ow   = cw_reg - adx;
        oh   = ch_reg - ady;

        sxf = x0_reg + ((dx_reg < 0) ? -dx_reg : CW'(0))
                     + ((dx_reg > 0) ? CW'(ow_m1_reg) : CW'(0));
        syf = (dy_reg > 0) ? (y0_reg + CW'(oh_m1_reg)) : (y0_reg - dy_reg);

        dxf = CW'(sxf_reg) + dx_reg;
        dyf = CW'(syf_reg) + dy_reg;
    end

    assign accept    = req_valid & req_ready;
    assign req_ready = (state_reg == S_IDLE) & ~out_valid_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_oor_next   = out_oor_reg;
        l_next     = l_reg;
        t_next     = t_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        cw_next    = cw_reg;
        ch_next    = ch_reg;
        ow_m1_next = ow_m1_reg;
        oh_m1_next = oh_m1_reg;
        sxf_next   = sxf_reg;
        syf_next   = syf_reg;

        wcmd.start   = 1'b0;
        wcmd.desc_x  = dx_reg > 0;
        wcmd.desc_y  = dy_reg > 0;
        wcmd.src     = AW'(syf_reg) * AW'(MAX_W) + AW'(sxf_reg);
        wcmd.dst     = AW'(dyf[YW-1:0]) * AW'(MAX_W) + AW'(dxf[XW-1:0]);
        wcmd.cols_m1 = ow_m1_reg;
        wcmd.rows_m1 = oh_m1_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    l_next  = l_in;
                    t_next  = t_in;
                    w_next  = CW'(span_w);
                    h_next  = CW'(span_h);
                    dx_next = CW'(shift_x);
                    dy_next = CW'(shift_y);
                    out_pix_next = '0;
                    out_oor_next = 1'b0;
                    case (req_type)
                        REQ_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            out_oor_next   = ~in_range;
                        end
                        REQ_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_oor_next   = 1'b1;
                            end
                        end
                        REQ_SCROLL:
                        begin
                            state_next = S_CLIP;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_pix_next   = ram_rdata;
                state_next     = S_IDLE;
            end
            S_CLIP:
            begin
                x0_next    = (l_reg < 0) ? CW'(0) : l_reg;
                y0_next    = (t_reg < 0) ? CW'(0) : t_reg;
                cw_next    = x1 - ((l_reg < 0) ? CW'(0) : l_reg);
                ch_next    = y1 - ((t_reg < 0) ? CW'(0) : t_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ow_m1_next = XW'(ow - CW'(1));
                oh_m1_next = YW'(oh - CW'(1));
                if (skip)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_ORIG;
                end
            end
            S_ORIG:
            begin
                sxf_next   = sxf[XW-1:0];
                syf_next   = syf[YW-1:0];
                state_next = S_START;
            end
            S_START:
            begin
                wcmd.start = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (wstat.done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // store ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = pixel_in;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (wstat.wr_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = wstat.wr_addr;
            ram_wdata = ram_rdata;
        end
        else if (accept && (req_type == REQ_WRITE) && in_range)
        begin
            ram_we = 1'b1;
        end

        ram_re    = wstat.rd_en | (accept && (req_type == REQ_READ) && in_range);
        ram_raddr = wstat.rd_en ? wstat.rd_addr : pix_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            aw_reg        <= SIZE_W'(256);
            ah_reg        <= SIZE_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            aw_reg        <= aw_next;
            ah_reg        <= ah_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg <= out_pix_next;
        out_oor_reg <= out_oor_next;
        l_reg       <= l_next;
        t_reg       <= t_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        cw_reg      <= cw_next;
        ch_reg      <= ch_next;
        ow_m1_reg   <= ow_m1_next;
        oh_m1_reg   <= oh_m1_next;
        sxf_reg     <= sxf_next;
        syf_reg     <= syf_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign out_of_range = out_oor_reg;

endmodule
